/* rtl/dbwt_pkg.sv */
// Package for the direction bin weighted tally unit.
// Holds payload structs, mode codes, sizing constants and the queue entry type.
// No dependencies.
package dbwt_pkg;

  localparam int MAX_OBSERVERS = 256;
  localparam int MAX_GROUPS    = 16;
  localparam int OBS_W         = $clog2(MAX_OBSERVERS);
  localparam int GRP_W         = $clog2(MAX_GROUPS);
  localparam int CELL_W        = OBS_W + GRP_W;
  localparam int BND_DEPTH     = MAX_GROUPS + 1;
  localparam int BND_W         = $clog2(BND_DEPTH);
  localparam int GCNT_W        = $clog2(BND_DEPTH + 1);
  localparam int OCNT_W        = OBS_W + 1;
  localparam int QDEPTH        = 2;

  localparam logic signed [47:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] E_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    MODE_LOAD_DIR = 2'd0,
    MODE_LOAD_BND = 2'd1,
    MODE_CROSS    = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_OBSERVERS = 3'd3,
    CFG_GROUPS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         index;
    logic [3:0]         group_sel;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] weight;
    logic [31:0]        frequency;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         bin;
    logic [3:0]         group_index;
    logic signed [47:0] bin_energy;
    logic [31:0]        bin_hits;
    logic signed [47:0] grp_energy;
    logic [31:0]        group_hits;
    logic               skipped;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    mode_t              mode;
    logic [7:0]         index;
    logic [3:0]         group_sel;
    logic signed [32:0] off_x;
    logic signed [32:0] off_y;
    logic signed [32:0] off_z;
    logic signed [31:0] weight;
    logic [31:0]        frequency;
    logic               skip;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_GRP,
    ST_RD,
    ST_RD2,
    ST_UPD,
    ST_OUT
  } bk_state_t;

endpackage

/* rtl/direction_bin_weighted_tally_unit.sv */
// Direction bin weighted tally unit, top level. B bins and G groups in use.
// A crossing scans all B directions and then searches the G group boundaries (no search
// when G is 1, no scan on a zero offset). The back end works on one transaction at a
// time; a two-entry queue lets the front keep accepting.
// Reset: synchronous, active low; a clearing pass then zeroes the accumulators,
// during which the back end takes nothing and the queue fills to two.
module direction_bin_weighted_tally_unit import dbwt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [8:0]         obs_r;
  logic [4:0]         grp_r;
  logic               q_valid, q_ready;
  work_t              q_data;
  in_item_t           in_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      obs_r <= 9'd1;
      grp_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:  cx_r  <= cfg_data;
        CFG_CENTER_Y:  cy_r  <= cfg_data;
        CFG_CENTER_Z:  cz_r  <= cfg_data;
        CFG_OBSERVERS: obs_r <= cfg_data[8:0];
        CFG_GROUPS:    grp_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // direction loads carry raw components: zero center through the front
  always_comb begin
    in_fix = in_data;
  end

  dbwt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_fix),
    .center_x ((in_data.mode == MODE_LOAD_DIR) ? 32'sd0 : cx_r),
    .center_y ((in_data.mode == MODE_LOAD_DIR) ? 32'sd0 : cy_r),
    .center_z ((in_data.mode == MODE_LOAD_DIR) ? 32'sd0 : cz_r),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  dbwt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .observer_count (obs_r),
    .group_count    (grp_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

/* rtl/dbwt_front.sv */
// Front end: accepts transactions, subtracts the center, flags skipped crossings.
// Depends on dbwt_pkg.
module dbwt_front import dbwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  output logic               q_valid,
  input  logic               q_ready,
  output work_t              q_data
);

  work_t                   mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  work_t                   w;
  logic                    push, pop;

  always_comb begin
    w.mode      = mode_t'(in_data.mode);
    w.index     = in_data.index;
    w.group_sel = in_data.group_sel;
    w.off_x     = 33'(in_data.vec_x) - 33'(center_x);
    w.off_y     = 33'(in_data.vec_y) - 33'(center_y);
    w.off_z     = 33'(in_data.vec_z) - 33'(center_z);
    w.weight    = in_data.weight;
    w.frequency = in_data.frequency;
    w.skip      = (in_data.mode == MODE_CROSS) && (in_data.weight == 32'sd0);
  end

  assign in_ready = (cnt_r != ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];
  assign cnt_nxt  = cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= w;
  end

endmodule

/* rtl/dbwt_back.sv */
// Back end: direction scan, group search, accumulator update and readout.
// Depends on dbwt_pkg; owns the direction, boundary and accumulator memories.
module dbwt_back import dbwt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  work_t          q_data,
  input  logic [8:0]     observer_count,
  input  logic [4:0]     group_count,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data
);

  logic [47:0] dir_mem   [MAX_OBSERVERS];
  logic [31:0] bnd_mem   [BND_DEPTH];
  logic [47:0] be_mem    [MAX_OBSERVERS];
  logic [31:0] bh_mem    [MAX_OBSERVERS];
  logic [47:0] ge_mem    [MAX_OBSERVERS*MAX_GROUPS];
  logic [31:0] gh_mem    [MAX_OBSERVERS*MAX_GROUPS];

  bk_state_t   st_r, st_nxt;
  work_t       wk_r;
  logic [CELL_W:0]   clr_r;
  logic [OBS_W-1:0]  scan_r;
  logic [OBS_W-1:0]  scan_idx_r;
  logic              dvalid_r;
  logic [47:0]       dir_q_r;
  logic signed [49:0] px_r, py_r, pz_r;
  logic              pvalid_r;
  logic [OBS_W-1:0]  pidx_r;
  logic signed [51:0] best_r;
  logic [OBS_W-1:0]  best_i_r;
  logic              have_r;
  logic [GCNT_W-1:0] gcnt_r;
  logic [BND_W-1:0]  gi_r;
  logic [GRP_W-1:0]  grp_r;
  logic [OBS_W-1:0]  bin_r;
  logic [47:0]       be_q_r, ge_q_r;
  logic [31:0]       bh_q_r, gh_q_r;
  out_item_t         res_r, res_nxt;
  logic              ov_r;

  logic [OCNT_W-1:0] nbins;
  logic [4:0]        ngrp;
  logic signed [51:0] dot;
  logic [CELL_W-1:0] acc_idx;
  logic signed [48:0] bsum, gsum;
  logic [47:0]       be_new, ge_new;
  logic [31:0]       bh_new, gh_new;
  logic              grp_on;
  logic [4:0]        gc_m1;
  logic [BND_W-1:0]  gi_end;
  logic              clr_busy;

  assign nbins = (observer_count == 9'd0) ? OCNT_W'(1) :
                 (observer_count > 9'(MAX_OBSERVERS)) ? OCNT_W'(MAX_OBSERVERS) :
                 OCNT_W'(observer_count);
  assign ngrp  = (group_count == 5'd0) ? 5'd1 :
                 (group_count > 5'(MAX_GROUPS)) ? 5'(MAX_GROUPS) : group_count;
  assign grp_on = (ngrp > 5'd1);
  assign gc_m1  = ngrp - 5'd1;
  assign gi_end = BND_W'(ngrp) + BND_W'(1);
  assign acc_idx = {bin_r, grp_r};
  assign clr_busy = !clr_r[CELL_W];
  assign q_ready  = (st_r == ST_IDLE) && !clr_busy;
  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign dot = 52'(px_r) + 52'(py_r) + 52'(pz_r);

  assign bsum = 49'($signed(be_q_r)) + 49'(wk_r.weight);
  assign gsum = 49'($signed(ge_q_r)) + 49'(wk_r.weight);
  assign be_new = (bsum > 49'(E_MAX)) ? E_MAX : (bsum < 49'(E_MIN)) ? E_MIN : bsum[47:0];
  assign ge_new = (gsum > 49'(E_MAX)) ? E_MAX : (gsum < 49'(E_MIN)) ? E_MIN : gsum[47:0];
  assign bh_new = (bh_q_r == 32'hFFFF_FFFF) ? bh_q_r : bh_q_r + 32'd1;
  assign gh_new = (gh_q_r == 32'hFFFF_FFFF) ? gh_q_r : gh_q_r + 32'd1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !clr_busy) begin
          case (q_data.mode)
            MODE_CROSS: begin
              if (q_data.skip) st_nxt = ST_OUT;
              else if (q_data.off_x == '0 && q_data.off_y == '0 && q_data.off_z == '0)
                st_nxt = ST_GRP;
              else st_nxt = ST_SCAN;
            end
            MODE_READ: st_nxt = ST_RD;
            default:   st_nxt = ST_OUT;
          endcase
        end
      end
      ST_SCAN:      if (OCNT_W'(scan_r) + 1'b1 >= nbins) st_nxt = ST_SCAN_LAST;
      ST_SCAN_LAST: if (!dvalid_r && !pvalid_r) st_nxt = ST_PICK;
      ST_PICK:      st_nxt = ST_GRP;
      ST_GRP:       if (!grp_on || gi_r == gi_end) st_nxt = ST_RD;
      ST_RD:        st_nxt = ST_RD2;
      ST_RD2:       st_nxt = (wk_r.mode == MODE_CROSS) ? ST_UPD : ST_OUT;
      ST_UPD:       st_nxt = ST_OUT;
      ST_OUT:       if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_nxt = '0;
    case (wk_r.mode)
      MODE_CROSS: begin
        res_nxt.skipped = wk_r.skip;
        if (!wk_r.skip) begin
          res_nxt.bin          = 8'(bin_r);
          res_nxt.group_index  = 4'(grp_r);
          res_nxt.bin_energy   = be_new;
          res_nxt.bin_hits     = bh_new;
          res_nxt.grp_energy   = grp_on ? ge_new : ge_q_r;
          res_nxt.group_hits   = grp_on ? gh_new : gh_q_r;
        end
      end
      MODE_READ: begin
        res_nxt.bin          = wk_r.index;
        res_nxt.group_index  = wk_r.group_sel;
        res_nxt.bin_energy   = be_q_r;
        res_nxt.bin_hits     = bh_q_r;
        res_nxt.grp_energy   = ge_q_r;
        res_nxt.group_hits   = gh_q_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      clr_r    <= '0;
      ov_r     <= 1'b0;
      dvalid_r <= 1'b0;
      pvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clr_busy) clr_r <= clr_r + 1'b1;
      dvalid_r <= (st_r == ST_SCAN);
      pvalid_r <= dvalid_r;
      if (st_r == ST_OUT && st_nxt == ST_IDLE) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid && !clr_busy) begin
      wk_r     <= q_data;
      scan_r   <= '0;
      have_r   <= 1'b0;
      best_i_r <= '0;
      gcnt_r   <= '0;
      gi_r     <= '0;
      bin_r    <= (q_data.mode == MODE_READ) ? OBS_W'(q_data.index) : '0;
      if (q_data.mode == MODE_READ)
        grp_r <= GRP_W'(q_data.group_sel);
      if (q_data.mode == MODE_LOAD_DIR)
        dir_mem[OBS_W'(q_data.index)] <=
          {q_data.off_x[15:0], q_data.off_y[15:0], q_data.off_z[15:0]};
    end
    if (st_r == ST_SCAN) begin
      scan_r <= scan_r + 1'b1;
    end
    dir_q_r    <= dir_mem[scan_r];
    scan_idx_r <= scan_r;
    if (dvalid_r) begin
      px_r   <= wk_r.off_x * $signed(dir_q_r[47:32]);
      py_r   <= wk_r.off_y * $signed(dir_q_r[31:16]);
      pz_r   <= wk_r.off_z * $signed(dir_q_r[15:0]);
      pidx_r <= scan_idx_r;
    end
    if (pvalid_r && (!have_r || dot > best_r)) begin
      best_r   <= dot;
      best_i_r <= pidx_r;
      have_r   <= 1'b1;
    end
    if (st_r == ST_PICK) bin_r <= best_i_r;
    if (st_r == ST_GRP) begin
      if (grp_on && gi_r != gi_end) begin
        gi_r <= gi_r + 1'b1;
        if (bnd_mem[gi_r] <= wk_r.frequency) gcnt_r <= gcnt_r + 1'b1;
      end else if (!grp_on || gcnt_r == '0) begin
        grp_r <= '0;
      end else if (5'(gcnt_r) - 5'd1 > gc_m1) begin
        grp_r <= GRP_W'(gc_m1);
      end else begin
        grp_r <= GRP_W'(gcnt_r - 1'b1);
      end
    end
    if (st_r == ST_RD) begin
      be_q_r <= be_mem[bin_r];
      bh_q_r <= bh_mem[bin_r];
      ge_q_r <= ge_mem[acc_idx];
      gh_q_r <= gh_mem[acc_idx];
    end
    if (st_r == ST_UPD) begin
      be_mem[bin_r] <= be_new;
      bh_mem[bin_r] <= bh_new;
      if (grp_on) begin
        ge_mem[acc_idx] <= ge_new;
        gh_mem[acc_idx] <= gh_new;
      end
    end else if (clr_busy) begin
      ge_mem[clr_r[CELL_W-1:0]] <= '0;
      gh_mem[clr_r[CELL_W-1:0]] <= '0;
      if (clr_r[CELL_W-1:0] < CELL_W'(MAX_OBSERVERS)) begin
        be_mem[clr_r[OBS_W-1:0]] <= '0;
        bh_mem[clr_r[OBS_W-1:0]] <= '0;
      end
    end
    if (st_r == ST_OUT && st_nxt == ST_IDLE) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid && !clr_busy && q_data.mode == MODE_LOAD_BND
        && q_data.index < 8'(BND_DEPTH))
      bnd_mem[BND_W'(q_data.index)] <= q_data.frequency;
  end

endmodule
